// File: rtl/core/ubds_pkg.sv
// ----------------------------------------------------------------------------
// ubds_pkg
// Shared widths, constants and sideband types for the baud divisor selector.
// ----------------------------------------------------------------------------
package ubds_pkg;

  localparam int CLK_W   = 28;            // core clock field
  localparam int BAUD_W  = 24;            // requested baud field
  localparam int DIV_W   = 16;            // divisor register field
  localparam int N_W     = 17;            // rounded divisor, 1..65536
  localparam int RATE_W  = 25;            // achieved rate, clk/8 at most

  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(16000000);
  localparam logic [N_W-1:0]   N_MAX     = N_W'(65536);

  // Fields that ride alongside the achieved-rate dividers.
  typedef struct packed {
    logic [BAUD_W-1:0] baud;
    logic [N_W-1:0]    n8;
    logic [N_W-1:0]    n16;
    logic              ok8;
    logic              ok16;
  } ubds_side_t;

endpackage

// File: rtl/core/uart_baud_divisor_select_top.sv
// ----------------------------------------------------------------------------
// uart_baud_divisor_select_top
// UART baud divisor selection between 16x normal and 8x double-speed modes.
// ----------------------------------------------------------------------------
// Each requested baud rate yields one result: the rounded divisors for 16x
// and 8x oversampling are derived from the configured core clock, the rate
// each achieves is computed, and double speed is chosen only when its
// absolute error is strictly smaller (ties go to 16x). A mode whose divisor
// falls outside 1..65536 is never chosen; with neither usable, invalid is set
// and the other fields are zero. A new transaction is accepted every cycle
// unless in_stall holds it. A request passes through the input register,
// the clock/baud divider (a capture register plus 28 stages, one quotient
// bit per stage), one rounding stage, the two-lane achieved-rate divider (a
// capture register plus 25 stages), and the compare/select output register.
// The whole pipeline advances together; in_stall follows out_stall
// only while a result sits in the output register. cfg_ready is always high;
// cpu_clock_hz must be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module uart_baud_divisor_select_top
  import ubds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CLK_W-1:0]  cfg_cpu_clock_hz,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BAUD_W-1:0] in_baud,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_double_speed,
  output logic [DIV_W-1:0]  out_divisor,
  output logic              out_invalid
);

  // Output register
  logic             out_valid_r;
  logic             dbl_r, inv_r;
  logic [DIV_W-1:0] div_r;

  // Global advance: everything moves unless a held result is stalled.
  logic en;
  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Core clock register
  logic [CLK_W-1:0] clk_hz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) clk_hz_r <= CLK_RESET;
    else if (cfg_valid) clk_hz_r <= cfg_cpu_clock_hz;
  end

  // Input register
  logic              v0_r;
  logic [BAUD_W-1:0] baud0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) baud0_r <= in_baud;
  end

  // q = floor(clk / baud); clk/2/baud is then floor(q/2)
  logic              q_v;
  logic [CLK_W-1:0]  q_quo, q_num;
  logic [BAUD_W-1:0] q_den;

  ubds_qdiv u_qdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v0_r),
    .in_num  (clk_hz_r),
    .in_den  (baud0_r),
    .out_v   (q_v),
    .out_quo (q_quo),
    .out_num (q_num),
    .out_den (q_den)
  );

  // Rounding stage: n8 = (q+4)/8, n16 = (q/2+4)/8, usability check
  logic [CLK_W-3:0]  n8_full, n16_full;
  logic              ok8, ok16;
  ubds_side_t        side_nxt;

  always_comb begin
    n8_full  = (CLK_W-2)'(({1'b0, q_quo} + (CLK_W+1)'(4)) >> 3);
    n16_full = (CLK_W-2)'(({2'b0, q_quo[CLK_W-1:1]} + (CLK_W+1)'(4)) >> 3);
    ok8  = (q_den != '0) && (n8_full != '0) && (n8_full <= (CLK_W-2)'(N_MAX));
    ok16 = (q_den != '0) && (n16_full != '0) && (n16_full <= (CLK_W-2)'(N_MAX));
    side_nxt.baud = q_den;
    side_nxt.n8   = n8_full[N_W-1:0];
    side_nxt.n16  = n16_full[N_W-1:0];
    side_nxt.ok8  = ok8;
    side_nxt.ok16 = ok16;
  end

  logic              v1_r;
  ubds_side_t        side1_r;
  logic [RATE_W-1:0] num8_r, num16_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= q_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side_nxt;
      num8_r  <= q_num[CLK_W-1:3];
      num16_r <= {1'b0, q_num[CLK_W-1:4]};
    end
  end

  // Achieved rates: clk/8/n8 and clk/16/n16
  logic              r_v;
  logic [RATE_W-1:0] got8, got16;
  ubds_side_t        r_side;

  ubds_rdiv u_rdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (v1_r),
    .in_num8   (num8_r),
    .in_num16  (num16_r),
    .in_side   (side1_r),
    .out_v     (r_v),
    .out_got8  (got8),
    .out_got16 (got16),
    .out_side  (r_side)
  );

  // Compare and select
  logic [RATE_W-1:0] err8, err16, baud_x;
  logic              pick8;
  logic [N_W-1:0]    chosen, chosen_m1;

  always_comb begin
    baud_x    = {1'b0, r_side.baud};
    err8      = (got8 > baud_x) ? got8 - baud_x : baud_x - got8;
    err16     = (got16 > baud_x) ? got16 - baud_x : baud_x - got16;
    pick8     = (r_side.ok8 && r_side.ok16) ? (err8 < err16) : r_side.ok8;
    chosen    = pick8 ? r_side.n8 : r_side.n16;
    chosen_m1 = chosen - N_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= r_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (!r_side.ok8 && !r_side.ok16) begin
        dbl_r <= 1'b0;
        div_r <= '0;
        inv_r <= 1'b1;
      end else begin
        dbl_r <= pick8;
        div_r <= chosen_m1[DIV_W-1:0];
        inv_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_double_speed = dbl_r;
  assign out_divisor      = div_r;
  assign out_invalid      = inv_r;

endmodule

// File: rtl/core/ubds_qdiv.sv
// ----------------------------------------------------------------------------
// ubds_qdiv
// Pipelined restoring divider, one quotient bit per stage: clock / baud.
// ----------------------------------------------------------------------------
module ubds_qdiv
  import ubds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [CLK_W-1:0]  in_num,
  input  logic [BAUD_W-1:0] in_den,
  output logic              out_v,
  output logic [CLK_W-1:0]  out_quo,
  output logic [CLK_W-1:0]  out_num,
  output logic [BAUD_W-1:0] out_den
);

  localparam int NS = CLK_W;

  logic              v_r   [NS+1];
  logic [CLK_W-1:0]  num_r [NS+1];
  logic [BAUD_W-1:0] den_r [NS+1];
  logic [BAUD_W-1:0] rem_r [NS+1];
  logic [CLK_W-1:0]  quo_r [NS+1];

  logic [BAUD_W-1:0] rem_nxt [NS];
  logic              ge      [NS];

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      logic [BAUD_W:0] trial;
      trial      = {rem_r[k], num_r[k][NS-1-k]};
      ge[k]      = (trial >= {1'b0, den_r[k]});
      rem_nxt[k] = ge[k] ? BAUD_W'(trial - {1'b0, den_r[k]}) : trial[BAUD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NS; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int k = 0; k < NS; k++) v_r[k+1] <= v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= in_num;
      den_r[0] <= in_den;
      rem_r[0] <= '0;
      quo_r[0] <= '0;
      for (int k = 0; k < NS; k++) begin
        num_r[k+1] <= num_r[k];
        den_r[k+1] <= den_r[k];
        rem_r[k+1] <= rem_nxt[k];
        quo_r[k+1] <= {quo_r[k][CLK_W-2:0], ge[k]};
      end
    end
  end

  assign out_v   = v_r[NS];
  assign out_quo = quo_r[NS];
  assign out_num = num_r[NS];
  assign out_den = den_r[NS];

endmodule

// File: rtl/core/ubds_rdiv.sv
// ----------------------------------------------------------------------------
// ubds_rdiv
// Two-lane pipelined restoring divider for the achieved baud rates.
// ----------------------------------------------------------------------------
module ubds_rdiv
  import ubds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [RATE_W-1:0] in_num8,
  input  logic [RATE_W-1:0] in_num16,
  input  ubds_side_t        in_side,
  output logic              out_v,
  output logic [RATE_W-1:0] out_got8,
  output logic [RATE_W-1:0] out_got16,
  output ubds_side_t        out_side
);

  localparam int NS = RATE_W;

  logic              v_r    [NS+1];
  ubds_side_t        side_r [NS+1];
  logic [RATE_W-1:0] num_r  [2][NS+1];
  logic [N_W-1:0]    rem_r  [2][NS+1];
  logic [RATE_W-1:0] quo_r  [2][NS+1];

  logic [N_W-1:0]    rem_nxt [2][NS];
  logic              ge      [2][NS];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < NS; k++) begin
        logic [N_W:0] trial;
        logic [N_W-1:0] den;
        den           = (l == 0) ? side_r[k].n8 : side_r[k].n16;
        trial         = {rem_r[l][k], num_r[l][k][NS-1-k]};
        ge[l][k]      = (trial >= {1'b0, den});
        rem_nxt[l][k] = ge[l][k] ? N_W'(trial - {1'b0, den}) : trial[N_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NS; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int k = 0; k < NS; k++) v_r[k+1] <= v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0]   <= in_side;
      num_r[0][0] <= in_num8;
      num_r[1][0] <= in_num16;
      for (int l = 0; l < 2; l++) begin
        rem_r[l][0] <= '0;
        quo_r[l][0] <= '0;
      end
      for (int k = 0; k < NS; k++) begin
        side_r[k+1] <= side_r[k];
        for (int l = 0; l < 2; l++) begin
          num_r[l][k+1] <= num_r[l][k];
          rem_r[l][k+1] <= rem_nxt[l][k];
          quo_r[l][k+1] <= {quo_r[l][k][RATE_W-2:0], ge[l][k]};
        end
      end
    end
  end

  assign out_v     = v_r[NS];
  assign out_got8  = quo_r[0][NS];
  assign out_got16 = quo_r[1][NS];
  assign out_side  = side_r[NS];

endmodule

// File: rtl/core/ubds_checker.sv
// ----------------------------------------------------------------------------
// ubds_checker
// Port-level assertions for the baud divisor selector, bound to the top.
// ----------------------------------------------------------------------------
module ubds_checker
  import ubds_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             cfg_ready,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_double_speed,
  input logic [DIV_W-1:0] out_divisor,
  input logic             out_invalid
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |-> (!out_double_speed && out_divisor == '0))
    else $error("invalid result carries nonzero fields");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_divisor)))
    else $error("stalled result changed");

endmodule

bind uart_baud_divisor_select_top ubds_checker u_ubds_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .cfg_ready        (cfg_ready),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_double_speed (out_double_speed),
  .out_divisor      (out_divisor),
  .out_invalid      (out_invalid)
);
